// ----- sv/mac_address_frame_router_top_macros.svh -----
// Assertion macros for the MAC address frame router.
`ifndef MAC_ADDRESS_FRAME_ROUTER_TOP_MACROS_SVH
`define MAC_ADDRESS_FRAME_ROUTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every edge outside reset.
`define MAFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MAFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MAFR_ASSERT(lbl, prop, msg)
`define MAFR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- sv/mafr_pkg.sv -----
// Shared types, constants and helpers of the MAC address frame router.
`timescale 1ns / 1ps
`default_nettype none

package mafr_pkg;

  localparam int DATA_W    = 64;
  localparam int KEEP_W    = 8;
  localparam int MAC_W     = 48;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_ALL      = 1'd1;

  // Output queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Port codes.
  localparam logic PORT_OTHER = 1'b0;
  localparam logic PORT_SHELL = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [KEEP_W-1:0] keep;
    logic              last;
    logic              port;
    logic              run_end;
  } result_t;

  // Items pushed into the output queue in one cycle: n is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             room2;
  } fifo_status_t;

  function automatic logic [DATA_W-1:0] swap_bytes(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      r[i*8 +: 8] = v[(DATA_W/8 - 1 - i)*8 +: 8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/mafr_out_fifo.sv -----
// Four-entry output queue that takes up to two items per cycle and gives one per cycle while the reader is ready.
`timescale 1ns / 1ps
`default_nettype none

module mafr_out_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mafr_pkg::push_t       push,
  output mafr_pkg::fifo_status_t     status,
  output logic                       rd_valid,
  input  wire logic                  rd_ready,
  output mafr_pkg::result_t          rd_data
);

  mafr_pkg::result_t mem_r [mafr_pkg::FIFO_DEPTH];

  logic [mafr_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mafr_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mafr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [mafr_pkg::PTR_W-1:0] wr_ptr_second;
  logic                       pop;

  assign rd_valid      = (count_r != '0);
  assign pop           = rd_valid && rd_ready;
  assign rd_data       = mem_r[rd_ptr_r];
  assign wr_ptr_second = wr_ptr_r + mafr_pkg::PTR_W'(1);

  assign wr_ptr_nxt = wr_ptr_r + mafr_pkg::PTR_W'(push.n);
  assign rd_ptr_nxt = rd_ptr_r + mafr_pkg::PTR_W'(pop);
  assign count_nxt  = count_r + mafr_pkg::CNT_W'(push.n) - mafr_pkg::CNT_W'(pop);

  assign status.count = count_r;
  assign status.room2 = (count_r <= mafr_pkg::CNT_W'(mafr_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_second] <= push.second;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mac_address_frame_router_top.sv -----
// Top level of the MAC address frame router.
`timescale 1ns / 1ps
`default_nettype none

`include "mac_address_frame_router_top_macros.svh"

// Routes 64-bit Ethernet frame beats by source MAC address. The block takes one beat per
// cycle while the output queue has room. The first beat of a frame longer than one beat
// is held and gives no output item; when the second beat arrives, the source MAC (bytes
// 6 and 7 of the first beat, bytes 0 to 3 of the second) is compared with match_address,
// and both beats leave, unchanged, tagged with the chosen port (shell on a match or with
// pass_all set). Later beats follow on the same port until last; a one-beat frame goes
// to the shell port only with pass_all. Results are written into a four-entry output
// queue and leave from its head, one per cycle while out_tready is high; the input is
// ready while the queue has two free entries, so a steady stream runs at one beat per
// cycle and stalls only when the output side stalls. Configuration writes are taken in
// any cycle outside reset; neither channel is ready while reset is held.
module mac_address_frame_router_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [71:0]                       in_tdata,  // beat_data[63:0], beat_keep[71:64]
  input  wire logic                              in_tlast,  // beat_last
  // Result stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [71:0]                            out_tdata, // out_data[63:0], out_keep[71:64]
  output logic                                   out_tlast, // out_last
  output logic [1:0]                             out_tuser, // out_port[0], run_end[1]
  // Configuration writes.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mafr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mafr_pkg::MAC_W-1:0]        cfg_data
);

  typedef enum logic [1:0] {
    ST_FIRST  = 2'd0,
    ST_SECOND = 2'd1,
    ST_STREAM = 2'd2
  } state_t;

  state_t state_r, state_nxt;

  logic [mafr_pkg::MAC_W-1:0]  match_addr_r;
  logic                        pass_all_r;
  logic [mafr_pkg::DATA_W-1:0] held_data_r;
  logic [mafr_pkg::KEEP_W-1:0] held_keep_r;
  logic                        held_last_r;
  logic                        route_r, route_nxt;

  logic [mafr_pkg::DATA_W-1:0] beat_data;
  logic [mafr_pkg::KEEP_W-1:0] beat_keep;
  logic                        in_fire;
  logic                        cfg_fire;
  logic [mafr_pkg::DATA_W-1:0] held_swapped;
  logic [mafr_pkg::DATA_W-1:0] beat_swapped;
  logic [mafr_pkg::MAC_W-1:0]  src_mac;
  logic                        shell_hit;

  mafr_pkg::push_t        push;
  mafr_pkg::fifo_status_t fifo_status;
  mafr_pkg::result_t      head;

  assign beat_data = in_tdata[mafr_pkg::DATA_W-1:0];
  assign beat_keep = in_tdata[mafr_pkg::DATA_W +: mafr_pkg::KEEP_W];

  assign in_tready = rst_n && fifo_status.room2;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = rst_n;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign held_swapped = mafr_pkg::swap_bytes(held_data_r);
  assign beat_swapped = mafr_pkg::swap_bytes(beat_data);
  assign src_mac      = {held_swapped[15:0], beat_swapped[63:32]};
  assign shell_hit    = pass_all_r || (src_mac == match_addr_r);

  always_comb begin
    push      = '0;
    state_nxt = state_r;
    route_nxt = route_r;
    push.second.data    = beat_data;
    push.second.keep    = beat_keep;
    push.second.last    = in_tlast;
    push.second.port    = route_r;
    push.second.run_end = 1'b1;
    push.first          = push.second;
    if (in_fire) begin
      unique case (state_r)
        ST_SECOND: begin
          route_nxt           = shell_hit;
          push.n              = 2'd2;
          push.first.data     = held_data_r;
          push.first.keep     = held_keep_r;
          push.first.last     = held_last_r;
          push.first.port     = shell_hit;
          push.first.run_end  = 1'b0;
          push.second.port    = shell_hit;
          state_nxt           = in_tlast ? ST_FIRST : ST_STREAM;
        end
        ST_STREAM: begin
          push.n = 2'd1;
          if (in_tlast) begin
            state_nxt = ST_FIRST;
          end
        end
        default: begin
          if (in_tlast) begin
            route_nxt       = pass_all_r ? mafr_pkg::PORT_SHELL : mafr_pkg::PORT_OTHER;
            push.n          = 2'd1;
            push.first.port = route_nxt;
            state_nxt       = ST_FIRST;
          end else begin
            state_nxt = ST_SECOND;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FIRST;
      route_r      <= mafr_pkg::PORT_OTHER;
      match_addr_r <= '0;
      pass_all_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      route_r <= route_nxt;
      if (cfg_fire) begin
        unique case (cfg_index)
          mafr_pkg::REG_MATCH_ADDRESS: match_addr_r <= cfg_data;
          mafr_pkg::REG_PASS_ALL:      pass_all_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // The first beat is kept for the address compare and replayed with the second.
  always_ff @(posedge clk) begin
    if (in_fire && (state_r != ST_SECOND) && (state_r != ST_STREAM)) begin
      held_data_r <= beat_data;
      held_keep_r <= beat_keep;
      held_last_r <= in_tlast;
    end
  end

  mafr_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .status   (fifo_status),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (head)
  );

  assign out_tdata = {head.keep, head.data};
  assign out_tlast = head.last;
  assign out_tuser = {head.run_end, head.port};

  `MAFR_ASSERT(a_queue_bound, fifo_status.count <= mafr_pkg::CNT_W'(mafr_pkg::FIFO_DEPTH), "output queue overflow")
  `MAFR_ASSERT(a_ready_room, in_tready |-> fifo_status.count <= mafr_pkg::CNT_W'(mafr_pkg::FIFO_DEPTH - 2), "input ready without room for two items")
  `MAFR_ASSERT(a_last_ends_frame, (in_fire && in_tlast) |=> (state_r == ST_FIRST), "frame did not end on its last beat")
  `MAFR_ASSERT(a_second_pushes_two, (in_fire && state_r == ST_SECOND) |=> (fifo_status.count >= mafr_pkg::CNT_W'(1)), "second beat left the queue empty")
  `MAFR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid right after reset")

endmodule

`default_nettype wire

// ----- sim/tb_mac_address_frame_router_top.sv -----
// Self-checking testbench of the MAC address frame router top level.
`timescale 1ns / 1ps

module tb_mac_address_frame_router_top;

  typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_STREAM} frame_phase_t;

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [71:0]                    in_tdata   = '0;  // beat_data[63:0], beat_keep[71:64]
  logic                           in_tlast   = 1'b0; // beat_last
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [71:0]                    out_tdata;         // out_data[63:0], out_keep[71:64]
  logic                           out_tlast;         // out_last
  logic [1:0]                     out_tuser;         // out_port[0], run_end[1]
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [mafr_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [mafr_pkg::MAC_W-1:0]     cfg_data   = '0;

  mac_address_frame_router_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // The clock starts low so that every process already waits at the first rising edge.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Predictor state: configuration and frame tracking as the block holds them.
  logic [mafr_pkg::MAC_W-1:0]  match_mac    = '0;
  logic                        pass_all_en  = 1'b0;
  frame_phase_t                frame_phase  = PH_FIRST;
  logic [mafr_pkg::DATA_W-1:0] held_data;
  logic [mafr_pkg::KEEP_W-1:0] held_keep;
  logic                        held_last;
  logic                        route_shell  = 1'b0;

  mafr_pkg::result_t expected_beats[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;
  int beats_sent    = 0;
  int results_seen  = 0;
  int shell_results = 0;
  int mismatches    = 0;
  int input_stalls  = 0;

  function automatic mafr_pkg::result_t make_result(input logic [mafr_pkg::DATA_W-1:0] d,
                                                    input logic [mafr_pkg::KEEP_W-1:0] k,
                                                    input logic l, input logic shell,
                                                    input logic fin);
    mafr_pkg::result_t r;
    r.data    = d;
    r.keep    = k;
    r.last    = l;
    r.port    = shell ? mafr_pkg::PORT_SHELL : mafr_pkg::PORT_OTHER;
    r.run_end = fin;
    return r;
  endfunction

  // Works out the beats that one accepted input beat sends out.
  function void route_beat(input logic [mafr_pkg::DATA_W-1:0] d,
                           input logic [mafr_pkg::KEEP_W-1:0] k, input logic l);
    logic [mafr_pkg::MAC_W-1:0] src_mac;
    case (frame_phase)
      PH_SECOND: begin
        // Source MAC is wire bytes 6,7 of the held beat then bytes 0..3 of this one.
        src_mac = {held_data[55:48], held_data[63:56], d[7:0], d[15:8], d[23:16], d[31:24]};
        route_shell = pass_all_en || (src_mac == match_mac);
        expected_beats.push_back(make_result(held_data, held_keep, held_last, route_shell, 1'b0));
        expected_beats.push_back(make_result(d, k, l, route_shell, 1'b1));
        frame_phase = l ? PH_FIRST : PH_STREAM;
      end
      PH_STREAM: begin
        expected_beats.push_back(make_result(d, k, l, route_shell, 1'b1));
        if (l) frame_phase = PH_FIRST;
      end
      default: begin
        held_data = d;
        held_keep = k;
        held_last = l;
        if (l) begin
          route_shell = pass_all_en;
          expected_beats.push_back(make_result(d, k, l, route_shell, 1'b1));
          frame_phase = PH_FIRST;
        end else begin
          frame_phase = PH_SECOND;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch in %s at %0t ns: expected %h, got %h", field, $time, want, got);
  endtask

  // Result checker: every accepted item is matched against the oldest expectation.
  always @(posedge clk) begin
    mafr_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser[0] == mafr_pkg::PORT_SHELL) shell_results++;
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected item data", '0, out_tdata[63:0]);
      end else begin
        want = expected_beats.pop_front();
        if (out_tdata[63:0] !== want.data) report_mismatch("data", want.data, out_tdata[63:0]);
        if (out_tdata[71:64] !== want.keep)
          report_mismatch("keep", 64'(want.keep), 64'(out_tdata[71:64]));
        if (out_tlast !== want.last) report_mismatch("last", 64'(want.last), 64'(out_tlast));
        if (out_tuser[0] !== want.port)
          report_mismatch("port", 64'(want.port), 64'(out_tuser[0]));
        if (out_tuser[1] !== want.run_end)
          report_mismatch("run_end", 64'(want.run_end), 64'(out_tuser[1]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) input_stalls++;
  end

  // Receiver: random idling, or a long hold-off while hold_cycles runs down.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles--;
    end else begin
      out_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(input logic [mafr_pkg::DATA_W-1:0] d,
                           input logic [mafr_pkg::KEEP_W-1:0] k, input logic l);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {k, d};
    in_tlast  = l;
    do @(posedge clk); while (!in_tready);
    route_beat(d, k, l);
    beats_sent++;
  endtask

  // Sends a frame of n_beats beats carrying the given source MAC.
  task automatic send_frame(input logic [mafr_pkg::MAC_W-1:0] mac, input int n_beats);
    logic [mafr_pkg::DATA_W-1:0] d;
    logic [mafr_pkg::KEEP_W-1:0] k;
    for (int i = 0; i < n_beats; i++) begin
      d = {$urandom, $urandom};
      if (i == 0) d[63:48] = {mac[39:32], mac[47:40]};
      if (i == 1) d[31:0] = {mac[7:0], mac[15:8], mac[23:16], mac[31:24]};
      k = (i == n_beats - 1 || $urandom_range(0, 9) == 0) ? 8'($urandom) : 8'hFF;
      send_beat(d, k, i == n_beats - 1);
    end
  endtask

  // Stops the input and waits until every expected item has arrived, plus a margin.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mafr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mafr_pkg::MAC_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == mafr_pkg::REG_MATCH_ADDRESS) match_mac = val;
    else pass_all_en = val[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [mafr_pkg::MAC_W-1:0] mac, input logic pass_all);
    drain_results();
    write_reg(mafr_pkg::REG_MATCH_ADDRESS, mac);
    write_reg(mafr_pkg::REG_PASS_ALL, {{(mafr_pkg::MAC_W-1){1'b0}}, pass_all});
  endtask

  function automatic logic [mafr_pkg::MAC_W-1:0] pick_mac();
    case ($urandom_range(0, 5))
      0, 1, 2: return match_mac;
      3:       return match_mac ^ (48'd1 << $urandom_range(0, mafr_pkg::MAC_W - 1));
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [mafr_pkg::MAC_W-1:0] pick_config_mac();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  // Reset values: address zero, no pass-all.
  task automatic test_reset_values();
    send_frame(48'h0, 3);
    send_frame(48'h0000_0000_0001, 2);
    send_beat({$urandom, $urandom}, 8'hFF, 1'b1);
  endtask

  task automatic test_directed();
    configure('1, 1'b0);
    send_beat('1, 8'hFF, 1'b0);
    send_beat('1, 8'h00, 1'b1);
    send_frame(48'h7FFF_FFFF_FFFF, 2);
    configure(48'h0123_4567_89AB, 1'b1);
    send_beat('0, 8'h01, 1'b1);
    send_frame(48'hFEDC_BA98_7654, 2);
    configure('0, 1'b0);
    send_beat('0, 8'h00, 1'b0);
    send_beat('0, 8'h80, 1'b1);
    send_frame(48'h0, 5);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_beats);
    int start;
    int len;
    int roll;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = beats_sent;
    configure(pick_config_mac(), $urandom_range(0, 3) == 0);
    while (beats_sent - start < n_beats) begin
      if ($urandom_range(0, 39) == 0) configure(pick_config_mac(), $urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 70) len = $urandom_range(1, 4);
      else if (roll < 95) len = $urandom_range(5, 8);
      else len = $urandom_range(9, 16);
      send_frame(pick_mac(), len);
    end
  endtask

  // The receiver stops for a long stretch so the output queue fills and the input stalls.
  task automatic test_output_stall();
    int start;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(pick_config_mac(), 1'b0);
    hold_cycles = 300;
    start = beats_sent;
    while (beats_sent - start < 40) send_frame(pick_mac(), $urandom_range(1, 6));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_values();
    test_directed();
    test_random_traffic(35, 60, 120);
    test_random_traffic(60, 35, 120);
    test_random_traffic(0, 0, 120);
    test_output_stall();
    drain_results();
    if (expected_beats.size() != 0) begin
      $display("%0d expected items never arrived", expected_beats.size());
      mismatches += expected_beats.size();
    end
    $display("Sent %0d beats in frames of 1 to 16 beats under three idling patterns;",
             beats_sent);
    $display("checked %0d items (%0d to shell), input stalled %0d cycles, %0d mismatches.",
             results_seen, shell_results, input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("mac_address_frame_router_top regression: pass");
    end else begin
      $display("mac_address_frame_router_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: simulation did not finish");
    $display("mac_address_frame_router_top regression: fail");
    $finish;
  end

endmodule

// ----- mac_address_frame_router_top.f -----
+incdir+sv
sv/mafr_pkg.sv
sv/mafr_out_fifo.sv
sv/mac_address_frame_router_top.sv
sim/tb_mac_address_frame_router_top.sv
